### hdl/acg_pkg.sv
// Shared types, constants and register codes for the congestion hold gate.
`timescale 1ns / 1ps
package acg_pkg;

  localparam int unsigned DLY_W  = 40;
  localparam int unsigned PMIL_W = 10;
  localparam int unsigned TS_W   = 64;
  localparam int unsigned CNT32_W = 32;
  localparam int unsigned RTT_W  = 29;
  localparam int unsigned D_W    = 42;
  localparam int unsigned PCT_W  = 8;
  localparam int unsigned PROD_W = D_W + PCT_W;
  localparam int unsigned DEN_W  = 32;
  localparam int unsigned LOSS_W = 42;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W + 1);

  localparam int unsigned SPLIT_W  = 25;
  localparam int unsigned QHI_W    = D_W - SPLIT_W;
  localparam int unsigned REM_W    = 7;
  localparam int unsigned RECIP_W  = 32;
  localparam int unsigned RPROD_W  = 2 * RECIP_W;
  localparam int unsigned RECIP_SH = 37;
  localparam logic [RECIP_W-1:0] RECIP_100 = 32'h51EB_851F;

  localparam logic [IDX_W-1:0] REG_DEFAULT_DELAY = 8'd0;
  localparam logic [IDX_W-1:0] REG_MIN_DELAY     = 8'd1;
  localparam logic [IDX_W-1:0] REG_MAX_DELAY     = 8'd2;
  localparam logic [IDX_W-1:0] REG_RTT_EXCELLENT = 8'd3;
  localparam logic [IDX_W-1:0] REG_RTT_GOOD      = 8'd4;
  localparam logic [IDX_W-1:0] REG_RTT_POOR      = 8'd5;
  localparam logic [IDX_W-1:0] REG_LOSS_LOW      = 8'd6;
  localparam logic [IDX_W-1:0] REG_LOSS_HIGH     = 8'd7;

  localparam logic [DLY_W-1:0]  DEFAULT_DELAY_RST = 40'd3000000000;
  localparam logic [DLY_W-1:0]  MIN_DELAY_RST     = 40'd500000000;
  localparam logic [DLY_W-1:0]  MAX_DELAY_RST     = 40'd10000000000;
  localparam logic [DLY_W-1:0]  RTT_EXCELLENT_RST = 40'd50000000;
  localparam logic [DLY_W-1:0]  RTT_GOOD_RST      = 40'd100000000;
  localparam logic [DLY_W-1:0]  RTT_POOR_RST      = 40'd200000000;
  localparam logic [PMIL_W-1:0] LOSS_LOW_RST      = 10'd10;
  localparam logic [PMIL_W-1:0] LOSS_HIGH_RST     = 10'd50;

  localparam logic [TS_W-1:0]   NS_1S      = 64'd1000000000;
  localparam logic [TS_W-1:0]   NS_5S      = 64'd5000000000;
  localparam logic [LOSS_W-1:0] PERMILLE   = 42'd1000;
  localparam logic [DLY_W-1:0]  NS_PER_US  = 40'd1000;
  localparam logic [LOSS_W-1:0] LOSS_MID   = 42'd30;
  localparam logic [CNT32_W-1:0] STREAK_LONG  = 32'd5;
  localparam logic [CNT32_W-1:0] STREAK_SHORT = 32'd3;
  localparam logic [DEN_W-1:0]  PCT_BASE   = 32'd100;

  localparam logic [PCT_W-1:0] PCT_NONE       = 8'd0;
  localparam logic [PCT_W-1:0] PCT_RTT_EXC    = 8'd60;
  localparam logic [PCT_W-1:0] PCT_RTT_GOOD   = 8'd80;
  localparam logic [PCT_W-1:0] PCT_RTT_POOR   = 8'd140;
  localparam logic [PCT_W-1:0] PCT_LOSS_LOW   = 8'd130;
  localparam logic [PCT_W-1:0] PCT_LOSS_HIGH  = 8'd70;
  localparam logic [PCT_W-1:0] PCT_LOSS_MID   = 8'd85;
  localparam logic [PCT_W-1:0] PCT_STREAK_LNG = 8'd50;
  localparam logic [PCT_W-1:0] PCT_STREAK_SHT = 8'd70;
  localparam logic [PCT_W-1:0] PCT_TIME_NEAR  = 8'd60;
  localparam logic [PCT_W-1:0] PCT_TIME_FAR   = 8'd120;

  typedef struct packed {
    logic [TS_W-1:0]    now_ns;
    logic [CNT32_W-1:0] srtt_scaled_us;
    logic [CNT32_W-1:0] segments_sent;
    logic [CNT32_W-1:0] lost_outstanding;
  } acg_in_t;

  typedef struct packed {
    logic               apply_growth;
    logic               congested;
    logic [DLY_W-1:0]   wait_delay_ns;
    logic [CNT32_W-1:0] streak_count;
  } acg_out_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [DLY_W-1:0] value;
  } acg_cfg_t;

  typedef struct packed {
    logic [DLY_W-1:0]  base_hold_ns;
    logic [DLY_W-1:0]  hold_floor_ns;
    logic [DLY_W-1:0]  hold_ceil_ns;
    logic [DLY_W-1:0]  rtt_excellent_ns;
    logic [DLY_W-1:0]  rtt_good_ns;
    logic [DLY_W-1:0]  rtt_poor_ns;
    logic [PMIL_W-1:0] loss_low_permille;
    logic [PMIL_W-1:0] loss_high_permille;
  } acg_regs_t;

endpackage

### hdl/acg_stream_if.sv
// Valid/ready channel carrying one payload of a given type.
`timescale 1ns / 1ps
interface acg_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/acg_regs.sv
// Configuration register file of the congestion hold gate.
`timescale 1ns / 1ps
module acg_regs
  import acg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  acg_stream_if.sink   cfg_ch,
  output acg_regs_t    regs
);

  acg_regs_t regs_r;

  assign cfg_ch.ready = 1'b1;
  assign regs         = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.base_hold_ns       <= DEFAULT_DELAY_RST;
      regs_r.hold_floor_ns      <= MIN_DELAY_RST;
      regs_r.hold_ceil_ns       <= MAX_DELAY_RST;
      regs_r.rtt_excellent_ns   <= RTT_EXCELLENT_RST;
      regs_r.rtt_good_ns        <= RTT_GOOD_RST;
      regs_r.rtt_poor_ns        <= RTT_POOR_RST;
      regs_r.loss_low_permille  <= LOSS_LOW_RST;
      regs_r.loss_high_permille <= LOSS_HIGH_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        REG_DEFAULT_DELAY: regs_r.base_hold_ns     <= cfg_ch.data.value;
        REG_MIN_DELAY:     regs_r.hold_floor_ns    <= cfg_ch.data.value;
        REG_MAX_DELAY:     regs_r.hold_ceil_ns     <= cfg_ch.data.value;
        REG_RTT_EXCELLENT: regs_r.rtt_excellent_ns <= cfg_ch.data.value;
        REG_RTT_GOOD:      regs_r.rtt_good_ns      <= cfg_ch.data.value;
        REG_RTT_POOR:      regs_r.rtt_poor_ns      <= cfg_ch.data.value;
        REG_LOSS_LOW:      regs_r.loss_low_permille  <= cfg_ch.data.value[PMIL_W-1:0];
        REG_LOSS_HIGH:     regs_r.loss_high_permille <= cfg_ch.data.value[PMIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/acg_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module acg_divider
  import acg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [DEN_W-1:0]  den,
  output logic              busy,
  output logic              done,
  output logic [PROD_W-1:0] quot
);

  logic [PROD_W-1:0]    quot_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DEN_W:0]       shifted;
  logic                 fits;
  logic [DEN_W:0]       diff;

  assign shifted = {rem_r, quot_r[PROD_W-1]};
  assign fits    = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quot_r <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= DIV_CNT_W'(PROD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quot_r <= {quot_r[PROD_W-2:0], fits};
        rem_r  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

### hdl/adaptive_congestion_hold_gate_unit.sv
// Top level of the adaptive congestion hold gate: state, sequencer and result register.
//
// Channels: in_ch takes one acknowledgement event per transfer (timestamp,
// scaled smoothed RTT, segments sent, segments lost outstanding). out_ch
// gives one result per event: growth permission, congestion flag, current
// hold time and loss streak. cfg_ch writes one register per transfer and is
// always ready; write only while the block is idle.
// Sequencing: an event that does not start congestion goes straight to the
// done state. An event that starts congestion recomputes the hold time:
// the loss permille goes through a 50-step serial divider (skipped when no
// segments were sent), then four percent steps, each of which scales
// through the shared 32x32 reciprocal multiplier when its percentage is
// not neutral, then clamp and load. in_ch is not ready meanwhile.
// The result is loaded into the result register once the output slot is free.
// Acceptance: a new event is taken only after the last result is loaded.
// Reset: all statistics clear, the hold time returns to 3 s and the
// registers to their defaults; no clearing pass.
// Stall: a finished result waits in the output register; the next event is
// accepted and worked on meanwhile, and its result waits for the slot.
`timescale 1ns / 1ps
module adaptive_congestion_hold_gate_unit
  import acg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  acg_stream_if.sink   in_ch,
  acg_stream_if.source out_ch,
  acg_stream_if.sink   cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOSS_GO, S_LOSS_WAIT, S_STEP, S_SCALE_HI, S_SCALE_REM, S_SCALE_LO,
    S_CLAMP, S_DONE
  } state_t;

  typedef enum logic [1:0] {STEP_RTT, STEP_LOSS, STEP_STREAK, STEP_TIME} step_t;

  acg_regs_t regs;

  state_t             state_r;
  step_t              step_r;
  step_t              step_nxt;
  logic [RTT_W-1:0]   rtt_us_r;
  logic [CNT32_W-1:0] sent_r;
  logic [CNT32_W-1:0] lost_r;
  logic [CNT32_W-1:0] streak_r;
  logic [TS_W-1:0]    last_loss_r;
  logic [DLY_W-1:0]   delay_r;
  logic [TS_W-1:0]    cstart_r;
  logic               cong_r;
  logic [TS_W-1:0]    now_r;
  logic [D_W-1:0]     d_r;
  logic [LOSS_W-1:0]  loss_r;
  logic [PROD_W-1:0]  prod_r;
  logic [QHI_W-1:0]   qhi_r;
  logic [RECIP_W-1:0] lo_arg_r;
  logic               out_valid_r;
  acg_out_t           out_r;

  logic               div_start;
  logic [PROD_W-1:0]  div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_busy;
  logic               div_done;
  logic [PROD_W-1:0]  div_quot;

  logic                      in_xfer;
  logic                      out_load;
  logic                      near_loss;
  logic [DLY_W-1:0]          rtt_ns;
  logic [TS_W-1:0]           since_loss;
  logic [PCT_W-1:0]          step_pct;
  logic [D_W-1:0]            d_lo;
  logic [D_W-1:0]            d_clamp;
  logic                      apply;
  logic [PROD_W-SPLIT_W-1:0] prod_hi;
  logic [RECIP_W-1:0]        recip_arg;
  logic [RPROD_W-1:0]        recip_prod;
  logic [RECIP_W-1:0]        recip_quot;
  logic [REM_W-1:0]          hi_rem;

  acg_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  acg_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign near_loss = (last_loss_r != '0) && ((in_ch.data.now_ns - last_loss_r) < NS_1S);

  assign div_start = (state_r == S_LOSS_GO) && (sent_r != '0);
  assign div_num   = PROD_W'(LOSS_W'(lost_r) * PERMILLE);
  assign div_den   = sent_r;

  // Divide by 100 in two halves through one reciprocal multiplier.
  assign prod_hi    = prod_r[PROD_W-1:SPLIT_W];
  assign recip_arg  = (state_r == S_SCALE_HI) ? RECIP_W'(prod_hi) : lo_arg_r;
  assign recip_prod = RPROD_W'(recip_arg) * RPROD_W'(RECIP_100);
  assign recip_quot = RECIP_W'(recip_prod >> RECIP_SH);
  assign hi_rem     = REM_W'(RECIP_W'(prod_hi) - RECIP_W'(qhi_r) * PCT_BASE);

  assign rtt_ns     = DLY_W'(rtt_us_r) * NS_PER_US;
  assign since_loss = now_r - last_loss_r;

  always_comb begin
    step_pct = PCT_NONE;
    case (step_r)
      STEP_RTT: begin
        if (rtt_ns < regs.rtt_excellent_ns)   step_pct = PCT_RTT_EXC;
        else if (rtt_ns < regs.rtt_good_ns)   step_pct = PCT_RTT_GOOD;
        else if (rtt_ns > regs.rtt_poor_ns)   step_pct = PCT_RTT_POOR;
      end
      STEP_LOSS: begin
        if (loss_r < LOSS_W'(regs.loss_low_permille))       step_pct = PCT_LOSS_LOW;
        else if (loss_r > LOSS_W'(regs.loss_high_permille)) step_pct = PCT_LOSS_HIGH;
        else if (loss_r > LOSS_MID)                         step_pct = PCT_LOSS_MID;
      end
      STEP_STREAK: begin
        if (streak_r > STREAK_LONG)       step_pct = PCT_STREAK_LNG;
        else if (streak_r > STREAK_SHORT) step_pct = PCT_STREAK_SHT;
      end
      STEP_TIME: begin
        if (last_loss_r != '0) begin
          if (since_loss < NS_1S)      step_pct = PCT_TIME_NEAR;
          else if (since_loss > NS_5S) step_pct = PCT_TIME_FAR;
        end
      end
      default: step_pct = PCT_NONE;
    endcase
  end

  always_comb begin
    case (step_r)
      STEP_RTT:    step_nxt = STEP_LOSS;
      STEP_LOSS:   step_nxt = STEP_STREAK;
      STEP_STREAK: step_nxt = STEP_TIME;
      default:     step_nxt = STEP_TIME;
    endcase
  end

  assign d_lo    = (d_r < D_W'(regs.hold_floor_ns)) ? D_W'(regs.hold_floor_ns) : d_r;
  assign d_clamp = (d_lo > D_W'(regs.hold_ceil_ns)) ? D_W'(regs.hold_ceil_ns) : d_lo;
  assign apply   = !cong_r || ((now_r - cstart_r) >= TS_W'(delay_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_RTT;
      rtt_us_r    <= '0;
      sent_r      <= '0;
      lost_r      <= '0;
      streak_r    <= '0;
      last_loss_r <= '0;
      delay_r     <= DEFAULT_DELAY_RST;
      cstart_r    <= '0;
      cong_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            now_r    <= in_ch.data.now_ns;
            rtt_us_r <= in_ch.data.srtt_scaled_us[CNT32_W-1:3];
            sent_r   <= in_ch.data.segments_sent;
            state_r  <= S_DONE;
            if (in_ch.data.lost_outstanding != '0) begin
              cong_r <= 1'b1;
              lost_r <= in_ch.data.lost_outstanding;
              if (in_ch.data.lost_outstanding > lost_r) begin
                streak_r    <= near_loss ? streak_r + 1'b1 : CNT32_W'(1);
                last_loss_r <= in_ch.data.now_ns;
              end
              if (cstart_r == '0) begin
                cstart_r <= in_ch.data.now_ns;
                d_r      <= D_W'(regs.base_hold_ns);
                step_r   <= STEP_RTT;
                state_r  <= S_LOSS_GO;
              end
            end else begin
              if (cong_r) begin
                streak_r <= '0;
              end
              cong_r   <= 1'b0;
              cstart_r <= '0;
            end
          end
        end
        S_LOSS_GO: begin
          if (sent_r == '0) begin
            loss_r  <= '0;
            state_r <= S_STEP;
          end else begin
            state_r <= S_LOSS_WAIT;
          end
        end
        S_LOSS_WAIT: begin
          if (div_done) begin
            loss_r  <= div_quot[LOSS_W-1:0];
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (step_pct != PCT_NONE) begin
            prod_r  <= PROD_W'(d_r) * PROD_W'(step_pct);
            state_r <= S_SCALE_HI;
          end else if (step_r == STEP_TIME) begin
            state_r <= S_CLAMP;
          end else begin
            step_r <= step_nxt;
          end
        end
        S_SCALE_HI: begin
          qhi_r   <= recip_quot[QHI_W-1:0];
          state_r <= S_SCALE_REM;
        end
        S_SCALE_REM: begin
          lo_arg_r <= {hi_rem, prod_r[SPLIT_W-1:0]};
          state_r  <= S_SCALE_LO;
        end
        S_SCALE_LO: begin
          d_r <= {qhi_r, recip_quot[SPLIT_W-1:0]};
          if (step_r == STEP_TIME) begin
            state_r <= S_CLAMP;
          end else begin
            step_r  <= step_nxt;
            state_r <= S_STEP;
          end
        end
        S_CLAMP: begin
          delay_r <= d_clamp[DLY_W-1:0];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_r.apply_growth  <= apply;
            out_r.congested     <= cong_r;
            out_r.wait_delay_ns <= delay_r;
            out_r.streak_count  <= streak_r;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_no_start_outside: assert property (@(posedge clk) disable iff (!rst_n)
    !cong_r |-> (cstart_r == '0))
    else $error("congestion start held outside congestion");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result not presented after completion");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_LOSS_WAIT))
    else $error("divider finished with no pass waiting");

endmodule
